// File: rtl/cpfa_pkg.sv
package cpfa_pkg;

    localparam int TAG_W   = 11;
    localparam int FRAME_W = 20;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] REG_BASE_FRAME  = 1'b0;
    localparam logic [CIDX_W-1:0] REG_FRAME_COUNT = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_RUN    = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] page_count;
        logic [FRAME_W-1:0] frame_number;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [FRAME_W-1:0] start_frame;
        logic [COUNT_W-1:0] run_length;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic    clear;
        logic    accept;
        logic    scan;
        logic    tag;
        logic    fscan;
        logic    load_res;
        status_t res_code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic req_bad;
        logic hit;
        logic exhausted;
        logic tag_last;
        logic fdone;
        logic fnone;
    } sts_t;

endpackage

// File: rtl/cpfa_ctrl.sv
module cpfa_ctrl
    import cpfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic out_stall,
    output logic out_valid,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_ATAG,
        S_FSCAN,
        S_RESP
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    status_t code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.res_code = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.req_bad)
                    begin
                        code_next  = sts.is_free ? ST_IGNORED : ST_NO_RUN;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = sts.is_free ? S_FSCAN : S_ASCAN;
                    end
                end
            end
            S_ASCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_ATAG;
                end
                else if (sts.exhausted)
                begin
                    code_next  = ST_NO_RUN;
                    state_next = S_RESP;
                end
            end
            S_ATAG:
            begin
                cmd.tag = 1'b1;
                if (sts.tag_last)
                begin
                    code_next  = ST_ALLOCATED;
                    state_next = S_RESP;
                end
            end
            S_FSCAN:
            begin
                cmd.fscan = 1'b1;
                if (sts.fdone)
                begin
                    code_next  = sts.fnone ? ST_IGNORED : ST_FREED;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall) || cmd.load_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            code_reg      <= ST_NO_RUN;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            code_reg      <= code_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/cpfa_dp.sv
module cpfa_dp
    import cpfa_pkg::*;
#(
    parameter int FRAMES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_item_t          in_data,
    output out_item_t         out_data,
    input  logic              cfg_write,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  cmd_t              cmd,
    output sts_t              sts
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW    = $clog2(FRAMES + 1);
    localparam int EW    = ((CW > TAG_W) ? CW : TAG_W) + 1;

    // tag store
    logic [TAG_W-1:0] mem [FRAMES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [TAG_W-1:0] mem_wdata;
    logic             mem_re;
    logic [TAG_W-1:0] rdata_reg;

    logic [FRAME_W-1:0] base_reg, base_next;
    logic [COUNT_W-1:0] fcount_reg, fcount_next;

    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      chk_reg, chk_next;
    logic [CW-1:0]      first_reg, first_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [COUNT_W-1:0] want_reg, want_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [EW-1:0]      expect_reg, expect_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    out_item_t          res_reg, res_next;

    logic [CW-1:0]      nman;
    logic [FRAME_W-1:0] off20;
    logic               in_range;
    logic               tag_zero;
    logic               tag_match;
    logic               more;
    logic [CW-1:0]      taddr;

    always_comb
    begin
        if (EW'(fcount_reg) > EW'(FRAMES))
        begin
            nman = CW'(FRAMES);
        end
        else
        begin
            nman = CW'(fcount_reg);
        end
        off20     = in_data.frame_number - base_reg;
        in_range  = (off20 < FRAME_W'(nman));
        tag_zero  = (rdata_reg == '0);
        tag_match = (EW'(rdata_reg) == expect_reg);
        more      = (idx_reg < nman);
        taddr     = first_reg + CW'(k_reg);

        sts.clear_last = (idx_reg == CW'(FRAMES - 1));
        sts.is_free    = (in_data.kind == KIND_FREE);
        if (in_data.kind == KIND_FREE)
        begin
            sts.req_bad = (in_data.frame_number == '0) || !in_range;
        end
        else
        begin
            sts.req_bad = (in_data.page_count == '0);
        end
        sts.hit       = rd_vld_reg && tag_zero && ((run_reg + 1'b1) == want_reg);
        sts.exhausted = !rd_vld_reg && !more;
        sts.tag_last  = ((k_reg + 1'b1) == want_reg);
        sts.fdone     = (rd_vld_reg && !tag_match) || (!rd_vld_reg && !more);
        sts.fnone     = (expect_reg == EW'(1));
    end

    always_comb
    begin
        base_next   = base_reg;
        fcount_next = fcount_reg;
        idx_next    = idx_reg;
        chk_next    = chk_reg;
        first_next  = first_reg;
        rd_vld_next = 1'b0;
        run_next    = run_reg;
        want_next   = want_reg;
        k_next      = k_reg;
        expect_next = expect_reg;
        frame_next  = frame_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[IDX_W-1:0];
        mem_wdata   = '0;
        mem_re      = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_FRAME:  base_next   = cfg_data[FRAME_W-1:0];
                REG_FRAME_COUNT: fcount_next = cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end

        if (cmd.clear)
        begin
            mem_we   = 1'b1;
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            want_next   = in_data.page_count;
            frame_next  = in_data.frame_number;
            idx_next    = (in_data.kind == KIND_FREE) ? CW'(off20) : '0;
            run_next    = '0;
            k_next      = '0;
            expect_next = EW'(1);
        end

        // issue reads one frame ahead of the check
        if (cmd.scan || cmd.fscan)
        begin
            if (more)
            begin
                mem_re      = 1'b1;
                idx_next    = idx_reg + 1'b1;
                chk_next    = idx_reg;
                rd_vld_next = 1'b1;
            end
        end

        if (cmd.scan && rd_vld_reg)
        begin
            if (tag_zero)
            begin
                run_next = run_reg + 1'b1;
                if (run_reg == '0)
                begin
                    first_next = chk_reg;
                end
            end
            else
            begin
                run_next = '0;
            end
        end

        if (cmd.tag)
        begin
            mem_we    = 1'b1;
            mem_waddr = taddr[IDX_W-1:0];
            mem_wdata = k_reg + 1'b1;
            k_next    = k_reg + 1'b1;
        end

        if (cmd.fscan && rd_vld_reg && tag_match)
        begin
            mem_we      = 1'b1;
            mem_waddr   = chk_reg[IDX_W-1:0];
            expect_next = expect_reg + 1'b1;
        end

        if (cmd.load_res)
        begin
            res_next.status = cmd.res_code;
            case (cmd.res_code)
                ST_ALLOCATED:
                begin
                    res_next.start_frame = base_reg + FRAME_W'(first_reg);
                    res_next.run_length  = want_reg;
                end
                ST_FREED:
                begin
                    res_next.start_frame = frame_reg;
                    res_next.run_length  = COUNT_W'(expect_reg - 1'b1);
                end
                default:
                begin
                    res_next.start_frame = '0;
                    res_next.run_length  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            fcount_reg <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            base_reg   <= base_next;
            fcount_reg <= fcount_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg    <= chk_next;
        first_reg  <= first_next;
        run_reg    <= run_next;
        want_reg   <= want_next;
        k_reg      <= k_next;
        expect_reg <= expect_next;
        frame_reg  <= frame_next;
        res_reg    <= res_next;
    end

    assign out_data = res_reg;

endmodule

// File: rtl/contiguous_page_frame_allocator.sv
// First-fit contiguous page frame allocator.
// Input channel (in_valid / in_stall / in_data) takes one request item: an
// allocate of page_count frames or a free of the run starting at
// frame_number. Output channel (out_valid / out_stall / out_data) returns
// exactly one result item per request. Configuration (cfg_write, cfg_index,
// cfg_data) sets base_frame and frame_count; write it only while idle.
// One request is in flight at a time. A tag memory with one read and one
// write port sets the pace: an allocate reads frames in the first-fit scan
// and then tags the run that it found, a free reads and clears the frames
// of the run, and a request rejected up front goes straight to its result.
// After reset the block sweeps all FRAMES frames of the tag memory to zero,
// one frame per cycle, with in_stall high; configuration writes are taken
// then. A finished result waits in the output register while out_stall is
// high; the block takes the next request meanwhile, but holds its result
// back until that item is taken.
module contiguous_page_frame_allocator
    import cpfa_pkg::*;
#(
    parameter int FRAMES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_write,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    cpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    cpfa_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: rtl/cpfa_checker.sv
module cpfa_checker
    import cpfa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_NO_RUN || out_data.status == ST_IGNORED)
        |-> out_data.start_frame == '0 && out_data.run_length == '0)
        else $error("failed request carries nonzero fields");

    a_alloc_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_ALLOCATED || out_data.status == ST_FREED)
        |-> out_data.run_length != '0)
        else $error("successful request with zero run length");

endmodule

bind contiguous_page_frame_allocator cpfa_checker u_cpfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
